// ===== sv/tap_change_voltage_relay_defines.svh =====
// Assertion macros for the tap change voltage relay.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef TAP_CHANGE_VOLTAGE_RELAY_DEFINES_SVH
`define TAP_CHANGE_VOLTAGE_RELAY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCVR_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("relay check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCVR_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("relay check failed");

`endif

// ===== sv/tcvr_pkg.sv =====
// Shared types and constants for the tap change voltage relay.
// No dependencies; every other source file but the defines header imports this package.
`timescale 1ns / 1ps

package tcvr_pkg;

  localparam int CHANNELS   = 3;
  localparam int TIME_BITS  = 24;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_W   = 15;
  localparam int CHAN_W     = 2;
  localparam int CNT_W      = 8;
  localparam int PERIOD_W   = 13;
  localparam int STEP_W     = 8;
  localparam int BUDGET_W   = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMING_MODE   = 3'd0,
    REG_UPPER_BOUND   = 3'd1,
    REG_LOWER_BOUND   = 3'd2,
    REG_DEFINITE_DLY  = 3'd3,
    REG_INVERSE_STEP  = 3'd4,
    REG_INVERSE_BUDG  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic {
    MODE_DEFINITE = 1'b0,
    MODE_INVERSE  = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                 timing_mode;
    logic [SAMPLE_W-1:0]   upper_bound;
    logic [SAMPLE_W-1:0]   lower_bound;
    logic [PERIOD_W-1:0]   definite_delay_ms;
    logic [STEP_W-1:0]     inverse_step_ms;
    logic [BUDGET_W-1:0]   inverse_budget;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    timing_mode:       MODE_DEFINITE,
    upper_bound:       15'd9830,
    lower_bound:       15'd6554,
    definite_delay_ms: 13'd5000,
    inverse_step_ms:   8'd10,
    inverse_budget:    30'd8191750
  };

  typedef struct packed {
    cmd_t                cmd;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample_value;
  } item_t;

  typedef struct packed {
    logic             alarm;
    logic             raise_tap;
    logic             lower_tap;
    logic [CNT_W-1:0] raise_total;
    logic [CNT_W-1:0] lower_total;
    logic             timing_active;
  } result_t;

  typedef struct packed {
    logic alarm_latched;
    logic progress_full;
  } status_t;

endpackage

// ===== sv/tcvr_if.sv =====
// Valid/ready channel interfaces for the relay input and result beats.
// Depends on tcvr_pkg for field widths.
`timescale 1ns / 1ps

interface tcvr_in_if import tcvr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [CHAN_W-1:0]   channel;
  logic [SAMPLE_W-1:0] sample_value;

  modport source (output valid, cmd, channel, sample_value, input ready);
  modport sink   (input valid, cmd, channel, sample_value, output ready);
endinterface

interface tcvr_out_if import tcvr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             alarm;
  logic             raise_tap;
  logic             lower_tap;
  logic [CNT_W-1:0] raise_total;
  logic [CNT_W-1:0] lower_total;
  logic             timing_active;

  modport source (output valid, alarm, raise_tap, lower_tap, raise_total, lower_total,
                  timing_active, input ready);
  modport sink   (input valid, alarm, raise_tap, lower_tap, raise_total, lower_total,
                  timing_active, output ready);
endinterface

// ===== sv/tcvr_cfg.sv =====
// Configuration register bank of the relay.
// Depends on tcvr_pkg for the register map and cfg_t.
`timescale 1ns / 1ps

module tcvr_cfg import tcvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_TIMING_MODE:  cfg_r.timing_mode       <= mode_t'(cfg_wdata[0]);
        REG_UPPER_BOUND:  cfg_r.upper_bound       <= cfg_wdata[SAMPLE_W-1:0];
        REG_LOWER_BOUND:  cfg_r.lower_bound       <= cfg_wdata[SAMPLE_W-1:0];
        REG_DEFINITE_DLY: cfg_r.definite_delay_ms <= cfg_wdata[PERIOD_W-1:0];
        REG_INVERSE_STEP: cfg_r.inverse_step_ms   <= cfg_wdata[STEP_W-1:0];
        REG_INVERSE_BUDG: cfg_r.inverse_budget    <= cfg_wdata[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/tcvr_core.sv =====
// Relay state and its registered update for one sample or tick beat.
// Depends on tcvr_pkg for item, config, result and status types.
`timescale 1ns / 1ps

module tcvr_core import tcvr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    go,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result,
  output status_t status
);

  localparam int PROD_W = TIME_BITS + SAMPLE_W;

  logic [SAMPLE_W-1:0]  rms_r [CHANNELS];
  logic [SAMPLE_W-1:0]  rms_nxt [CHANNELS];
  logic                 latched_r, latched_nxt;
  logic [CH_IDX_W-1:0]  watched_r, watched_nxt;
  logic                 timer_r, timer_nxt;
  logic [PERIOD_W-1:0]  pcount_r, pcount_nxt;
  logic [TIME_BITS-1:0] trav_r, trav_nxt;
  logic                 pfull_r, pfull_nxt;
  logic                 alarm_r, alarm_nxt;
  logic                 raise_r, raise_nxt;
  logic                 lower_r, lower_nxt;
  logic [CNT_W-1:0]     rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0]     lcnt_r, lcnt_nxt;

  logic [CH_IDX_W-1:0]  ch_idx;
  logic                 ch_ok;
  logic [SAMPLE_W-1:0]  watched_v;
  logic                 over, under;
  logic [SAMPLE_W-1:0]  excess;
  logic [TIME_BITS:0]   t_sum;
  logic [TIME_BITS-1:0] t_sat;
  logic [PROD_W-1:0]    prod;
  logic [PERIOD_W-1:0]  period;
  logic [PERIOD_W:0]    pc_inc;
  logic                 any_oob;
  logic [SAMPLE_W-1:0]  chk_v;

  function automatic logic out_of_band(input logic [SAMPLE_W-1:0] v, input cfg_t c);
    return (v > c.upper_bound) || (v < c.lower_bound);
  endfunction

  always_comb begin
    ch_idx    = CH_IDX_W'(item.channel);
    ch_ok     = int'(item.channel) < CHANNELS;
    watched_v = rms_r[watched_r];
    over      = watched_v > cfg.upper_bound;
    under     = watched_v < cfg.lower_bound;
    excess    = over ? (watched_v - cfg.upper_bound) : (cfg.lower_bound - watched_v);
    t_sum     = {1'b0, trav_r} + (TIME_BITS + 1)'(cfg.inverse_step_ms);
    t_sat     = t_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : t_sum[TIME_BITS-1:0];
    prod      = PROD_W'(t_sat) * PROD_W'(excess);
    period    = (cfg.timing_mode == MODE_INVERSE) ? PERIOD_W'(cfg.inverse_step_ms)
                                                  : cfg.definite_delay_ms;
    pc_inc    = {1'b0, pcount_r} + (PERIOD_W + 1)'(1);

    // Band check over all channels with the new sample already in place.
    any_oob = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      chk_v   = (CH_IDX_W'(i) == ch_idx) ? item.sample_value : rms_r[i];
      any_oob = any_oob | out_of_band(chk_v, cfg);
    end

    rms_nxt     = rms_r;
    latched_nxt = latched_r;
    watched_nxt = watched_r;
    timer_nxt   = timer_r;
    pcount_nxt  = pcount_r;
    trav_nxt    = trav_r;
    pfull_nxt   = pfull_r;
    alarm_nxt   = alarm_r;
    raise_nxt   = raise_r;
    lower_nxt   = lower_r;
    rcnt_nxt    = rcnt_r;
    lcnt_nxt    = lcnt_r;

    if (go) begin
      case (item.cmd)
        CMD_SAMPLE: begin
          if (ch_ok) begin
            rms_nxt[ch_idx] = item.sample_value;
            if (out_of_band(item.sample_value, cfg)) begin
              if (!latched_r) begin
                latched_nxt = 1'b1;
                alarm_nxt   = 1'b1;
                watched_nxt = ch_idx;
                timer_nxt   = 1'b1;
                pcount_nxt  = '0;
                trav_nxt    = '0;
                pfull_nxt   = 1'b0;
              end
            end else if (latched_r && (watched_r == ch_idx)) begin
              latched_nxt = 1'b0;
              timer_nxt   = 1'b0;
              trav_nxt    = '0;
              pfull_nxt   = 1'b0;
              if (!any_oob) begin
                alarm_nxt = 1'b0;
                raise_nxt = 1'b0;
                lower_nxt = 1'b0;
              end
            end
          end
        end
        CMD_TICK: begin
          if (timer_r) begin
            if (pc_inc >= {1'b0, period}) begin
              pcount_nxt = '0;
              if (cfg.timing_mode == MODE_DEFINITE) begin
                if (over) begin
                  lower_nxt = 1'b1;
                  lcnt_nxt  = lcnt_r + CNT_W'(1);
                end else if (under) begin
                  raise_nxt = 1'b1;
                  rcnt_nxt  = rcnt_r + CNT_W'(1);
                end else begin
                  timer_nxt = 1'b0;
                  alarm_nxt = 1'b0;
                  raise_nxt = 1'b0;
                  lower_nxt = 1'b0;
                end
              end else if (!over && !under) begin
                alarm_nxt = 1'b0;
                raise_nxt = 1'b0;
                lower_nxt = 1'b0;
                trav_nxt  = '0;
                pfull_nxt = 1'b0;
              end else if (!pfull_r) begin
                trav_nxt  = t_sat;
                pfull_nxt = prod >= PROD_W'(cfg.inverse_budget);
              end else begin
                if (over) begin
                  lower_nxt = 1'b1;
                  lcnt_nxt  = lcnt_r + CNT_W'(1);
                end else begin
                  raise_nxt = 1'b1;
                  rcnt_nxt  = rcnt_r + CNT_W'(1);
                end
                trav_nxt  = '0;
                pfull_nxt = 1'b0;
              end
            end else begin
              pcount_nxt = pc_inc[PERIOD_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rms_r[i] <= '0;
      end
      latched_r <= 1'b0;
      watched_r <= '0;
      timer_r   <= 1'b0;
      pcount_r  <= '0;
      trav_r    <= '0;
      pfull_r   <= 1'b0;
      alarm_r   <= 1'b0;
      raise_r   <= 1'b0;
      lower_r   <= 1'b0;
      rcnt_r    <= '0;
      lcnt_r    <= '0;
    end else begin
      rms_r     <= rms_nxt;
      latched_r <= latched_nxt;
      watched_r <= watched_nxt;
      timer_r   <= timer_nxt;
      pcount_r  <= pcount_nxt;
      trav_r    <= trav_nxt;
      pfull_r   <= pfull_nxt;
      alarm_r   <= alarm_nxt;
      raise_r   <= raise_nxt;
      lower_r   <= lower_nxt;
      rcnt_r    <= rcnt_nxt;
      lcnt_r    <= lcnt_nxt;
    end
  end

  assign result = '{
    alarm:         alarm_r,
    raise_tap:     raise_r,
    lower_tap:     lower_r,
    raise_total:   rcnt_r,
    lower_total:   lcnt_r,
    timing_active: timer_r
  };

  assign status = '{alarm_latched: latched_r, progress_full: pfull_r};

endmodule

// ===== sv/tap_change_voltage_relay.sv =====
// Top level of the tap change voltage relay: input stage, config bank, core.
// Depends on tcvr_pkg, the channel interfaces, tcvr_cfg, tcvr_core and the defines header.
`timescale 1ns / 1ps
`include "tap_change_voltage_relay_defines.svh"

// Three-channel RMS voltage relay for a transformer tap changer. Each input
// beat is either an RMS sample for one channel or a one millisecond tick, and
// each input beat yields exactly one result beat that reports the alarm,
// raise and lower signal levels, the wrapping raise and lower operation
// counts and whether the delay timer runs. The block takes one beat per clock
// cycle when the result side keeps up. An accepted beat waits in the input
// register until the core can take it; the state registers, which double as
// the result register, then take the update and present the result. The
// cycle time is set by the inverse-time check, a saturating add followed by
// a 24 by 15 bit multiply and a compare against the budget. The user must
// write configuration through the cfg_ port while no beat is in flight; the
// block itself does not enforce this. A write takes effect on the next beat.

module tap_change_voltage_relay import tcvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tcvr_in_if.sink               in_bus,
  tcvr_out_if.source            out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Input register: holds one accepted beat until the core can take it.
  logic    in_v_r, in_v_nxt;
  item_t   item_r;
  logic    out_v_r, out_v_nxt;
  logic    proc_go;
  logic    in_take;
  cfg_t    cfg;
  result_t result;
  status_t core_stat;

  // The core advances only when the result register is free or being drained,
  // so the state registers double as the result register.
  assign proc_go      = in_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !in_v_r || proc_go;
  assign in_take      = in_bus.valid && in_bus.ready;

  always_comb begin
    in_v_nxt = in_take ? 1'b1 : (proc_go ? 1'b0 : in_v_r);
    if (proc_go) begin
      out_v_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // The payload register needs no reset; it is qualified by in_v_r.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{
        cmd:          cmd_t'(in_bus.cmd),
        channel:      in_bus.channel,
        sample_value: in_bus.sample_value
      };
    end
  end

  tcvr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tcvr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (proc_go),
    .item   (item_r),
    .cfg    (cfg),
    .result (result),
    .status (core_stat)
  );

  assign out_bus.valid         = out_v_r;
  assign out_bus.alarm         = result.alarm;
  assign out_bus.raise_tap     = result.raise_tap;
  assign out_bus.lower_tap     = result.lower_tap;
  assign out_bus.raise_total   = result.raise_total;
  assign out_bus.lower_total   = result.lower_total;
  assign out_bus.timing_active = result.timing_active;

  // The timer only ever runs while an alarm is latched on some channel.
  `TCVR_CHECK_NOW(a_timer_needs_latch, out_bus.timing_active, core_stat.alarm_latched)
  // The raise count moves by exactly one step whenever it moves.
  `TCVR_CHECK_NOW(a_raise_step, out_bus.raise_total != $past(out_bus.raise_total),
                  out_bus.raise_total == $past(out_bus.raise_total) + 8'd1)
  // Without a processed beat the reported state cannot change.
  `TCVR_CHECK_NEXT(a_state_holds, !proc_go,
                   $stable(out_bus.raise_total) && $stable(out_bus.lower_total) &&
                   $stable(out_bus.timing_active) && $stable(out_bus.alarm))

endmodule

// ===== bench/tcvr_relay_checker.sv =====
// Checker for the tap change voltage relay: watches the input, result and register ports,
// keeps its own copy of the relay state and compares every result beat in order.
// Depends on tcvr_pkg and the tcvr_in_if / tcvr_out_if channel interfaces.
`timescale 1ns / 1ps

module tcvr_relay_checker import tcvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tcvr_in_if                    in_mon,
  tcvr_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    backlog,
  output int                    mismatches
);

  cfg_t                 regs;
  logic [SAMPLE_W-1:0]  rms [CHANNELS];
  logic                 latched;
  logic [CHAN_W-1:0]    watch_ch;
  logic                 timer_run;
  logic [PERIOD_W-1:0]  period_cnt;
  logic [TIME_BITS-1:0] travelled;
  logic                 full;
  logic                 sig_alarm, sig_raise, sig_lower;
  logic [CNT_W-1:0]     n_raise, n_lower;
  result_t              predicted_outputs [$];
  int                   errs = 0;

  function automatic logic beyond_band(input logic [SAMPLE_W-1:0] v);
    return (v > regs.upper_bound) || (v < regs.lower_bound);
  endfunction

  function automatic logic [SAMPLE_W-1:0] watched_rms();
    return (watch_ch < CHANNELS) ? rms[watch_ch] : '0;
  endfunction

  function automatic void definite_period();
    logic [SAMPLE_W-1:0] v;
    v = watched_rms();
    if (v > regs.upper_bound) begin
      sig_lower = 1'b1;
      n_lower   = n_lower + 8'd1;
    end else if (v < regs.lower_bound) begin
      sig_raise = 1'b1;
      n_raise   = n_raise + 8'd1;
    end else begin
      // Back in band at check time: stop timing, the latch itself stays.
      timer_run = 1'b0;
      {sig_alarm, sig_raise, sig_lower} = '0;
    end
  endfunction

  function automatic void inverse_period();
    logic [SAMPLE_W-1:0] v;
    logic                over, under;
    longint unsigned     excess, sum, ceiling;
    v       = watched_rms();
    over    = v > regs.upper_bound;
    under   = v < regs.lower_bound;
    ceiling = (64'd1 << TIME_BITS) - 64'd1;
    if (!over && !under) begin
      {sig_alarm, sig_raise, sig_lower} = '0;
      travelled = '0;
      full      = 1'b0;
    end else if (!full) begin
      excess = over ? (v - regs.upper_bound) : (regs.lower_bound - v);
      sum    = travelled + regs.inverse_step_ms;
      if (sum > ceiling) sum = ceiling;
      travelled = sum[TIME_BITS-1:0];
      full      = (sum * excess) >= regs.inverse_budget;
    end else begin
      if (over) begin
        sig_lower = 1'b1;
        n_lower   = n_lower + 8'd1;
      end else begin
        sig_raise = 1'b1;
        n_raise   = n_raise + 8'd1;
      end
      travelled = '0;
      full      = 1'b0;
    end
  endfunction

  function automatic void tick_ms();
    int unsigned span, next_cnt;
    if (!timer_run) return;
    span     = (regs.timing_mode == MODE_INVERSE) ? regs.inverse_step_ms
                                                  : regs.definite_delay_ms;
    next_cnt = period_cnt;
    next_cnt = next_cnt + 1;
    if (next_cnt >= span) begin
      period_cnt = '0;
      if (regs.timing_mode == MODE_INVERSE) inverse_period();
      else definite_period();
    end else begin
      period_cnt = period_cnt + 1'b1;
    end
  endfunction

  function automatic void take_reading(input logic [CHAN_W-1:0] ch,
                                       input logic [SAMPLE_W-1:0] v);
    if (ch >= CHANNELS) return;
    rms[ch] = v;
    if (beyond_band(v)) begin
      if (!latched) begin
        latched    = 1'b1;
        sig_alarm  = 1'b1;
        watch_ch   = ch;
        timer_run  = 1'b1;
        period_cnt = '0;
        travelled  = '0;
        full       = 1'b0;
      end
      return;
    end
    if (latched && watch_ch == ch) begin
      latched   = 1'b0;
      timer_run = 1'b0;
      travelled = '0;
      full      = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        if (beyond_band(rms[i])) return;
      end
      {sig_alarm, sig_raise, sig_lower} = '0;
    end
  endfunction

  function automatic result_t relay_step(input item_t it);
    result_t r;
    if (it.cmd == CMD_TICK) tick_ms();
    else take_reading(it.channel, it.sample_value);
    r.alarm         = sig_alarm;
    r.raise_tap     = sig_raise;
    r.lower_tap     = sig_lower;
    r.raise_total   = n_raise;
    r.lower_total   = n_lower;
    r.timing_active = timer_run;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    item_t   beat;
    result_t seen, want;
    if (!rst_n) begin
      regs       = CFG_RESET;
      foreach (rms[i]) rms[i] = '0;
      latched    = 1'b0;
      watch_ch   = '0;
      timer_run  = 1'b0;
      period_cnt = '0;
      travelled  = '0;
      full       = 1'b0;
      {sig_alarm, sig_raise, sig_lower} = '0;
      n_raise    = '0;
      n_lower    = '0;
      predicted_outputs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_TIMING_MODE:  regs.timing_mode       = mode_t'(cfg_wdata[0]);
          REG_UPPER_BOUND:  regs.upper_bound       = cfg_wdata[SAMPLE_W-1:0];
          REG_LOWER_BOUND:  regs.lower_bound       = cfg_wdata[SAMPLE_W-1:0];
          REG_DEFINITE_DLY: regs.definite_delay_ms = cfg_wdata[PERIOD_W-1:0];
          REG_INVERSE_STEP: regs.inverse_step_ms   = cfg_wdata[STEP_W-1:0];
          REG_INVERSE_BUDG: regs.inverse_budget    = cfg_wdata[BUDGET_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        beat.cmd          = cmd_t'(in_mon.cmd);
        beat.channel      = in_mon.channel;
        beat.sample_value = in_mon.sample_value;
        predicted_outputs.push_back(relay_step(beat));
      end
      if (out_mon.valid && out_mon.ready) begin
        seen.alarm         = out_mon.alarm;
        seen.raise_tap     = out_mon.raise_tap;
        seen.lower_tap     = out_mon.lower_tap;
        seen.raise_total   = out_mon.raise_total;
        seen.lower_total   = out_mon.lower_total;
        seen.timing_active = out_mon.timing_active;
        if (predicted_outputs.size() == 0) begin
          errs++;
          $display("%0t: result beat with nothing expected, expected none actual %h",
                   $time, seen);
        end else begin
          want = predicted_outputs.pop_front();
          check_field("alarm",         want.alarm,         seen.alarm);
          check_field("raise_tap",     want.raise_tap,     seen.raise_tap);
          check_field("lower_tap",     want.lower_tap,     seen.lower_tap);
          check_field("raise_total",   want.raise_total,   seen.raise_total);
          check_field("lower_total",   want.lower_total,   seen.lower_total);
          check_field("timing_active", want.timing_active, seen.timing_active);
        end
      end
    end
    backlog    <= predicted_outputs.size();
    mismatches <= errs;
  end

endmodule

// ===== bench/tb.sv =====
// Top of the tap change voltage relay bench: clock, reset, register writes and beat traffic.
// Depends on tcvr_pkg, the channel interfaces, tcvr_relay_checker and the relay itself.
`timescale 1ns / 1ps

module tb;
  import tcvr_pkg::*;

  // A run is stuck when this many cycles pass without a beat on either side.
  localparam int STALL_LIMIT   = 2000;
  // Extra cycles that settle waits once every expected result is back;
  // they cover any trailing work.
  localparam int DRAIN_CYCLES  = 4;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BEATS   = 60;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // While calm is set neither side inserts idle cycles.
  bit calm;
  int backlog, mismatches;
  int quiet_cycles;
  int beats_sent;
  int settings_used;

  tcvr_in_if  in_bus ();
  tcvr_out_if out_bus ();

  tap_change_voltage_relay u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  tcvr_relay_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .backlog    (backlog),
    .mismatches (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls at random, about 11 percent of the time, unless calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  // Watchdog: any accepted beat on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, giving up", $time, STALL_LIMIT);
      $display("tap_change_voltage_relay test failed");
      $finish;
    end
  end

  // Presents one beat and returns at the edge where it is accepted. Idle
  // cycles before the beat carry junk payload with valid low, so the relay
  // must ignore everything that is not qualified by valid.
  task automatic send_beat(input item_t it);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_bus.valid        <= 1'b0;
      in_bus.cmd          <= 1'($urandom);
      in_bus.channel      <= CHAN_W'($urandom);
      in_bus.sample_value <= SAMPLE_W'($urandom);
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.cmd          <= it.cmd;
    in_bus.channel      <= it.channel;
    in_bus.sample_value <= it.sample_value;
    do @(posedge clk); while (!in_bus.ready);
    beats_sent++;
  endtask

  task automatic put_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] v);
    send_beat('{cmd: CMD_SAMPLE, channel: ch, sample_value: v});
  endtask

  // The channel and value of a tick are don't-care, so they get random bits.
  task automatic put_tick();
    send_beat('{cmd: CMD_TICK, channel: CHAN_W'($urandom),
                sample_value: SAMPLE_W'($urandom)});
  endtask

  // Stops the input side and waits until every expected result has come
  // back, then waits out DRAIN_CYCLES more so the relay is surely idle.
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The gap cycle after each write keeps cfg_we from being dropped and
  // raised again within a single time step.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    settle();
    write_reg(REG_TIMING_MODE,  CFG_DATA_W'(c.timing_mode));
    write_reg(REG_UPPER_BOUND,  CFG_DATA_W'(c.upper_bound));
    write_reg(REG_LOWER_BOUND,  CFG_DATA_W'(c.lower_bound));
    write_reg(REG_DEFINITE_DLY, CFG_DATA_W'(c.definite_delay_ms));
    write_reg(REG_INVERSE_STEP, CFG_DATA_W'(c.inverse_step_ms));
    write_reg(REG_INVERSE_BUDG, CFG_DATA_W'(c.inverse_budget));
    settings_used++;
  endtask

  // Register settings per random phase. Phases past the fixed ones keep timer
  // periods short so that the tap actually moves within a phase; the fixed
  // phases hit the register extremes, including a zero period (which the
  // relay treats as one), an empty band (everything out of band, most values
  // over and under at once) and a band covering the whole converter range.
  function automatic cfg_t phase_settings(input int p);
    cfg_t c;
    c = CFG_RESET;
    case (p)
      0: begin
        c.definite_delay_ms = 13'd1;
      end
      1: begin
        c.timing_mode     = MODE_INVERSE;
        c.inverse_step_ms = 8'd1;
        c.inverse_budget  = BUDGET_W'($urandom_range(1, 2000));
      end
      2: begin
        c.definite_delay_ms = PERIOD_W'($urandom_range(2, 6));
      end
      3: begin
        c.timing_mode     = MODE_INVERSE;
        c.inverse_step_ms = 8'd255;
        c.inverse_budget  = 30'd1;
      end
      4: begin
        c.definite_delay_ms = 13'd8191;
        c.upper_bound       = 15'd32767;
        c.lower_bound       = 15'd0;
      end
      5: begin
        c.timing_mode     = MODE_INVERSE;
        c.inverse_step_ms = STEP_W'($urandom_range(1, 4));
        c.inverse_budget  = 30'h3FFF_FFFF;
        c.upper_bound     = 15'd0;
        c.lower_bound     = 15'd32767;
      end
      6: begin
        c.definite_delay_ms = 13'd0;
        c.upper_bound       = SAMPLE_W'($urandom_range(8000, 12000));
        c.lower_bound       = SAMPLE_W'($urandom_range(4000, 8000));
      end
      7: begin
        c.timing_mode     = MODE_INVERSE;
        c.inverse_step_ms = 8'd0;
        c.inverse_budget  = 30'd1;
      end
      default: begin
        c.timing_mode       = mode_t'($urandom_range(0, 1));
        c.definite_delay_ms = PERIOD_W'($urandom_range(1, 8));
        c.inverse_step_ms   = STEP_W'($urandom_range(1, 4));
        c.inverse_budget    = BUDGET_W'($urandom_range(1, 50000));
        c.upper_bound       = SAMPLE_W'($urandom_range(8000, 12000));
        c.lower_bound       = SAMPLE_W'($urandom_range(4000, 8000));
      end
    endcase
    return c;
  endfunction

  // Random beat: a bit more than half are ticks so timers run out, and the
  // samples cluster inside the band and just past either edge so alarms are
  // raised, held and cleared over and over. Now and then a sample goes to
  // the unused channel index or takes a value at either end of the range.
  function automatic item_t random_beat(input cfg_t c);
    item_t it;
    int    v, hi, lo;
    hi = c.upper_bound;
    lo = c.lower_bound;
    it.cmd     = ($urandom_range(0, 99) < 55) ? CMD_TICK : CMD_SAMPLE;
    it.channel = ($urandom_range(0, 19) == 0) ? CHAN_W'(3)
                                              : CHAN_W'($urandom_range(0, CHANNELS - 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(lo, hi);
      4, 5:       v = hi + int'($urandom_range(1, 20));
      6, 7:       v = lo - int'($urandom_range(1, 20));
      8:          v = $urandom_range(0, 1) ? 32767 : 0;
      default:    v = $urandom_range(0, 32767);
    endcase
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    it.sample_value = SAMPLE_W'(v);
    return it;
  endfunction

  initial begin
    cfg_t c;
    in_bus.valid        = 1'b0;
    in_bus.cmd          = CMD_SAMPLE;
    in_bus.channel      = '0;
    in_bus.sample_value = '0;
    out_bus.ready       = 1'b0;
    calm                = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first under the reset settings. A tick with the timer
    // stopped changes nothing; a second out-of-band channel does not move
    // the latch; the latched channel returning to band while another one is
    // still out keeps the signals up; the unused channel index is ignored;
    // a value equal to a bound counts as in band.
    put_tick();
    put_sample(2'd0, 15'd8000);
    put_sample(2'd1, 15'd0);
    put_sample(2'd2, 15'd32767);
    put_tick();
    put_sample(2'd1, 15'd8000);
    put_sample(2'd2, 15'd8000);
    put_sample(2'd0, 15'd32767);
    put_sample(2'd3, 15'd32767);
    put_sample(2'd3, 15'd0);
    put_sample(2'd0, 15'd9830);

    // Definite time with a one tick period: the tap moves on every tick.
    c = CFG_RESET;
    c.definite_delay_ms = 13'd1;
    load_settings(c);
    put_sample(2'd0, 15'd6553);
    put_tick();
    put_tick();
    put_sample(2'd0, 15'd6554);
    put_sample(2'd1, 15'd9831);
    put_tick();

    // Inverse time with a tiny budget, timer still running from above:
    // one count over the bound needs three steps, then a lower fires; a
    // deep undervoltage fills the budget in one step, then a raise fires.
    c.timing_mode     = MODE_INVERSE;
    c.inverse_step_ms = 8'd1;
    c.inverse_budget  = 30'd3;
    load_settings(c);
    put_tick();
    put_tick();
    put_tick();
    put_tick();
    put_sample(2'd1, 15'd0);
    put_tick();
    put_tick();
    put_sample(2'd1, 15'd7000);

    // Random phases, each under its own register settings. Phase 2 runs
    // with no idle cycles on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c    = phase_settings(p);
      calm = (p == 2);
      load_settings(c);
      repeat (PHASE_BEATS) send_beat(random_beat(c));
    end
    calm = 1'b0;

    settle();
    $display("Sent %0d beats under %0d register settings, both timing modes,", beats_sent,
             settings_used);
    $display("with random idle cycles on both sides and one stretch without any.");
    if (mismatches == 0) begin
      $display("tap_change_voltage_relay test passed");
    end else begin
      $display("tap_change_voltage_relay test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tcvr_pkg.sv
sv/tcvr_if.sv
sv/tcvr_cfg.sv
sv/tcvr_core.sv
sv/tap_change_voltage_relay.sv
bench/tcvr_relay_checker.sv
bench/tb.sv
